/* hw/rtl/uvst_pkg.sv */
// shared types and constants for the unique value set table
package uvst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 7;
    localparam int VAL_W       = 32;
    localparam int CMD_W       = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] item_value;
    } t_in_word;

    typedef struct packed {
        logic             success;
        logic [CNT_W-1:0] item_count;
        logic             is_empty;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

/* hw/rtl/uvst_ram.sv */
// entry storage: one write port, one read port, registered read data
module uvst_ram (
    input  logic                    i_clk,
    input  uvst_pkg::t_ram_req      i_req,
    output logic [uvst_pkg::VAL_W-1:0] o_rd_data
);
    import uvst_pkg::*;

    logic [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/uvst_ctrl.sv */
// command sequencer: scans the table, then appends, moves or reports
module uvst_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  uvst_pkg::t_in_word         i_in_word,
    input  logic [uvst_pkg::CNT_W-1:0] i_cap,
    output uvst_pkg::t_ram_req         o_ram_req,
    input  logic [uvst_pkg::VAL_W-1:0] i_rd_data,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output uvst_pkg::t_out_word        o_res
);
    import uvst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state,    n_state;
    logic [CMD_W-1:0]  r_cmd,      n_cmd;
    logic [VAL_W-1:0]  r_val,      n_val;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [CNT_W-1:0]  r_rd_idx,   n_rd_idx;
    logic              r_pend,     n_pend;
    logic [ADDR_W-1:0] r_pend_idx, n_pend_idx;
    logic              r_found,    n_found;
    logic [ADDR_W-1:0] r_slot,     n_slot;
    logic              r_ok,       n_ok;

    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  last_idx;
    logic              hit;

    assign limit    = (i_cap < DEPTH_CNT) ? i_cap : DEPTH_CNT;
    assign last_idx = r_count - CNT_W'(1);
    assign hit      = r_pend && (i_rd_data == r_val);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_found    = r_found;
        n_slot     = r_slot;
        n_ok       = r_ok;
        o_ram_req  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_word.command;
                    n_val    = i_in_word.item_value;
                    n_rd_idx = '0;
                    n_found  = 1'b0;
                    n_ok     = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // reads issue one a cycle, the compare follows in the next cycle
                if (r_rd_idx < r_count) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_rd_idx[ADDR_W-1:0];
                    n_pend          = 1'b1;
                    n_pend_idx      = r_rd_idx[ADDR_W-1:0];
                    n_rd_idx        = r_rd_idx + CNT_W'(1);
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_slot  = r_pend_idx;
                    n_pend  = 1'b0;
                    n_state = S_ACT;
                end else if (r_rd_idx == r_count) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_ADD: begin
                        if (!r_found && (r_count < limit)) begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_count[ADDR_W-1:0];
                            o_ram_req.wdata = r_val;
                            n_count         = r_count + CNT_W'(1);
                            n_ok            = 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_found) begin
                            // fetch the last entry to fill the freed slot
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = last_idx[ADDR_W-1:0];
                            n_ok            = 1'b1;
                            n_state         = S_MOVE;
                        end
                    end
                    CMD_SEARCH: begin
                        n_ok = r_found;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            S_MOVE: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_slot;
                o_ram_req.wdata = i_rd_data;
                n_count         = last_idx;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_found    <= n_found;
        r_slot     <= n_slot;
        r_ok       <= n_ok;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_res_valid      = (r_state == S_DONE);
    assign o_res.success    = r_ok;
    assign o_res.item_count = r_count;
    assign o_res.is_empty   = (r_count == '0);

endmodule

/* hw/rtl/unique_value_set_table.sv */
// top level: capacity register, sequencer, entry memory, result register
//
//  channel  | valid       | ready       | word
//  ---------+-------------+-------------+--------------------------
//  input    | i_in_valid  | o_in_ready  | i_in_word  (t_in_word)
//  result   | o_out_valid | i_out_ready | o_out_word (t_out_word)
//  config   | i_cfg_valid | o_cfg_ready | i_cfg_data (bag_capacity)
//
// an item takes one memory read per held entry, set by the single read port
// of the entry memory, plus accept, act and hand-off; a remove that hits also
// moves the last entry into the freed slot
// a new word is taken while the previous result waits in the output register
// synchronous reset clears the count and control; entries are not cleared
module unique_value_set_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  uvst_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output uvst_pkg::t_out_word        o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [uvst_pkg::CNT_W-1:0] i_cfg_data
);
    import uvst_pkg::*;

    logic [CNT_W-1:0] r_cap;
    logic             r_out_valid;
    t_out_word        r_out_word;

    t_ram_req         ram_req;
    logic [VAL_W-1:0] rd_data;
    logic             res_valid;
    logic             res_ready;
    t_out_word        res;

    assign res_ready = !r_out_valid || i_out_ready;

    uvst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_cap       (r_cap),
        .o_ram_req   (ram_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    uvst_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
        if (res_ready && res_valid) begin
            r_out_word <= res;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
